// File: design/ukst_pkg.sv
// ----------------------------------------------------------------------------
// ukst_pkg
// Shared types and constants for the unique key set table: command and
// status codes, controller states, and the controller/datapath link structs.
// ----------------------------------------------------------------------------
package ukst_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_W         = 8;
  localparam int ENTRY_COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the request fields
    logic exec;       // run add/remove/query or empty dump, emit one result
    logic dump_emit;  // emit the entry at the dump index and advance it
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_dump;    // captured request is a dump
    logic empty;      // no entries stored
    logic dump_last;  // dump index points at the final stored entry
  } dp_stat_t;

endpackage

// File: design/ukst_ctrl.sv
// ----------------------------------------------------------------------------
// ukst_ctrl
// Sequencer for the key set table: accepts a request, runs it and, for a
// dump, steps through the stored entries one per cycle.
// ----------------------------------------------------------------------------
module ukst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ukst_pkg::dp_stat_t stat,
  output ukst_pkg::ctrl_cmd_t cmd
);
  import ukst_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_dump && !stat.empty) begin
          cmd.dump_emit = 1'b1;
          state_nxt     = stat.dump_last ? S_IDLE : S_DUMP;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        cmd.dump_emit = 1'b1;
        state_nxt     = stat.dump_last ? S_IDLE : S_DUMP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/ukst_dp.sv
// ----------------------------------------------------------------------------
// ukst_dp
// Datapath of the key set table: entry registers, parallel key match,
// append, compacting remove, dump read and the result register.
// ----------------------------------------------------------------------------
module ukst_dp #(
  parameter int CAPACITY = ukst_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ukst_pkg::ctrl_cmd_t                  cmd,
  output ukst_pkg::dp_stat_t                   stat,
  input  logic [1:0]                           in_cmd,
  input  logic [ukst_pkg::KEY_W-1:0]           in_key_bank,
  input  logic [ukst_pkg::KEY_W-1:0]           in_key_sensor,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic                                 out_hit,
  output logic [ukst_pkg::ENTRY_COUNT_W-1:0]   out_entry_count,
  output logic [ukst_pkg::KEY_W-1:0]           out_bank,
  output logic [ukst_pkg::KEY_W-1:0]           out_sensor,
  output logic                                 out_last
);
  import ukst_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Request capture
  cmd_t             req_cmd_r;
  logic [KEY_W-1:0] req_bank_r;
  logic [KEY_W-1:0] req_sensor_r;

  // Entry storage and control
  logic [KEY_W-1:0] bank_r   [CAPACITY];
  logic [KEY_W-1:0] sensor_r [CAPACITY];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [IDX_W-1:0] idx_r;

  // Result register
  logic                     valid_r;
  status_t                  status_r;
  logic                     hit_r;
  logic [ENTRY_COUNT_W-1:0] count_r;
  logic [KEY_W-1:0]         bank_out_r;
  logic [KEY_W-1:0]         sensor_out_r;
  logic                     last_r;

  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] shift_en;
  logic                found;
  logic                full;
  logic                do_add;
  logic                do_remove;

  // Match the captured key against every live entry
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]    = (CNT_W'(i) < cnt_r) && (bank_r[i] == req_bank_r) &&
                    (sensor_r[i] == req_sensor_r);
      seen        = seen | match[i];
      shift_en[i] = seen;
    end
  end

  assign found = |match;
  assign full  = (cnt_r == CNT_W'(CAPACITY));

  assign do_add    = cmd.exec && (req_cmd_r == CMD_ADD) && !full && !found;
  assign do_remove = cmd.exec && (req_cmd_r == CMD_REMOVE) && found;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_add) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_remove) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign stat.is_dump   = (req_cmd_r == CMD_DUMP);
  assign stat.empty     = (cnt_r == '0);
  assign stat.dump_last = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  // Capture the request fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd_r    <= cmd_t'(in_cmd);
      req_bank_r   <= in_key_bank;
      req_sensor_r <= in_key_sensor;
    end
  end

  // Append on add, compact down on remove
  always_ff @(posedge clk) begin
    if (do_add) begin
      bank_r[cnt_r[IDX_W-1:0]]   <= req_bank_r;
      sensor_r[cnt_r[IDX_W-1:0]] <= req_sensor_r;
    end else if (do_remove) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (shift_en[i]) begin
          bank_r[i]   <= bank_r[i+1];
          sensor_r[i] <= sensor_r[i+1];
        end
      end
    end
  end

  // Count and dump index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.dump_emit) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.exec || cmd.dump_emit;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.dump_emit) begin
      status_r     <= ST_OK;
      hit_r        <= 1'b0;
      count_r      <= ENTRY_COUNT_W'(cnt_r);
      bank_out_r   <= bank_r[idx_r];
      sensor_out_r <= sensor_r[idx_r];
      last_r       <= stat.dump_last;
    end else if (cmd.exec) begin
      status_r     <= ST_OK;
      hit_r        <= 1'b0;
      count_r      <= ENTRY_COUNT_W'(cnt_nxt);
      bank_out_r   <= '0;
      sensor_out_r <= '0;
      last_r       <= 1'b1;
      case (req_cmd_r)
        CMD_ADD: begin
          if (full) begin
            status_r <= ST_FULL;
          end
        end
        CMD_REMOVE: begin
          if (!found) begin
            status_r <= ST_MISSING;
          end
        end
        CMD_QUERY: begin
          hit_r <= found;
        end
        default: begin
          // empty dump: all zero but last
        end
      endcase
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_hit         = hit_r;
  assign out_entry_count = count_r;
  assign out_bank        = bank_out_r;
  assign out_sensor      = sensor_out_r;
  assign out_last        = last_r;

  // Count stays within the table
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Dump reads only live entries
  a_dump_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dump_emit |-> (CNT_W'(idx_r) < cnt_r))
    else $error("dump index beyond stored entries");

  // Add on a full table reports full and leaves the count alone
  a_add_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (req_cmd_r == CMD_ADD) && full) |=>
      (valid_r && (status_r == ST_FULL) && $stable(cnt_r)))
    else $error("add on full table mishandled");

  // Remove that finds nothing keeps the count
  a_rem_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (req_cmd_r == CMD_REMOVE) && !found) |=>
      ((status_r == ST_MISSING) && $stable(cnt_r)))
    else $error("remove miss mishandled");

endmodule

// File: design/unique_key_set_table.sv
// ----------------------------------------------------------------------------
// unique_key_set_table
// Bounded set of unique (bank, sensor) keys, packed in insertion order, with
// add, remove with compaction, membership query and full dump.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. For add, remove and
// query the request is captured, then all stored entries are compared in
// parallel and the table is appended or compacted; the single result shows on
// the out_ ports for one cycle with out_valid high, and busy drops in that
// same cycle so the next request can follow at once. A dump of N entries
// streams one entry per cycle with out_valid high on each and out_last on the
// final one; a dump of an empty table gives one all-zero result with out_last
// set. The receiver cannot stall: every result must be taken in the cycle it
// is shown.
module unique_key_set_table #(
  parameter int CAPACITY = ukst_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_cmd,
  input  logic [ukst_pkg::KEY_W-1:0]           in_key_bank,
  input  logic [ukst_pkg::KEY_W-1:0]           in_key_sensor,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic                                 out_hit,
  output logic [ukst_pkg::ENTRY_COUNT_W-1:0]   out_entry_count,
  output logic [ukst_pkg::KEY_W-1:0]           out_bank,
  output logic [ukst_pkg::KEY_W-1:0]           out_sensor,
  output logic                                 out_last
);
  import ukst_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // Sequencer
  ukst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (ctrl_cmd)
  );

  // Storage and result path
  ukst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (ctrl_cmd),
    .stat            (dp_stat),
    .in_cmd          (in_cmd),
    .in_key_bank     (in_key_bank),
    .in_key_sensor   (in_key_sensor),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_hit         (out_hit),
    .out_entry_count (out_entry_count),
    .out_bank        (out_bank),
    .out_sensor      (out_sensor),
    .out_last        (out_last)
  );

endmodule

// File: tb/unique_key_set_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_key_set_table_checker
// Watches the request and result channels of the key set table, keeps its own
// copy of the stored keys, predicts every result of each accepted request and
// compares the results as they stream out, field by field and in order.
// ----------------------------------------------------------------------------
module unique_key_set_table_checker #(
  parameter int CAPACITY = ukst_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [1:0]                           in_cmd,
  input  logic [ukst_pkg::KEY_W-1:0]           in_key_bank,
  input  logic [ukst_pkg::KEY_W-1:0]           in_key_sensor,
  input  logic                                 out_valid,
  input  logic [1:0]                           out_status,
  input  logic                                 out_hit,
  input  logic [ukst_pkg::ENTRY_COUNT_W-1:0]   out_entry_count,
  input  logic [ukst_pkg::KEY_W-1:0]           out_bank,
  input  logic [ukst_pkg::KEY_W-1:0]           out_sensor,
  input  logic                                 out_last,
  output int                                   mismatch_count,
  output int                                   results_outstanding
);
  import ukst_pkg::*;

  typedef struct packed {
    status_t                    status;
    logic                       hit;
    logic [ENTRY_COUNT_W-1:0]   count;
    logic [KEY_W-1:0]           bank;
    logic [KEY_W-1:0]           sensor;
    logic                       last;
  } table_result_t;

  // Shadow copy of the stored keys
  logic [KEY_W-1:0] key_banks [CAPACITY];
  logic [KEY_W-1:0] key_sensors [CAPACITY];
  int               key_fill;

  table_result_t    expected_results [$];

  initial begin
    mismatch_count      = 0;
    results_outstanding = 0;
    key_fill            = 0;
  end

  // Position of the key among the stored entries, or -1 if absent
  function automatic int locate_key(logic [KEY_W-1:0] bank, logic [KEY_W-1:0] sensor);
    for (int i = 0; i < key_fill; i++) begin
      if (key_banks[i] == bank && key_sensors[i] == sensor) return i;
    end
    return -1;
  endfunction

  function automatic void push_result(status_t status, logic hit, logic [KEY_W-1:0] bank,
                                      logic [KEY_W-1:0] sensor, logic last);
    table_result_t r;
    r.status = status;
    r.hit    = hit;
    r.count  = key_fill[ENTRY_COUNT_W-1:0];
    r.bank   = bank;
    r.sensor = sensor;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  // Update the shadow table for one request and queue the results it causes
  function automatic void apply_request(cmd_t cmd, logic [KEY_W-1:0] bank,
                                        logic [KEY_W-1:0] sensor);
    int pos;
    pos = locate_key(bank, sensor);
    case (cmd)
      CMD_ADD: begin
        if (key_fill >= CAPACITY) begin
          push_result(ST_FULL, 1'b0, '0, '0, 1'b1);
        end else begin
          if (pos < 0) begin
            key_banks[key_fill]   = bank;
            key_sensors[key_fill] = sensor;
            key_fill++;
          end
          push_result(ST_OK, 1'b0, '0, '0, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (pos < 0) begin
          push_result(ST_MISSING, 1'b0, '0, '0, 1'b1);
        end else begin
          for (int i = pos; i + 1 < key_fill; i++) begin
            key_banks[i]   = key_banks[i + 1];
            key_sensors[i] = key_sensors[i + 1];
          end
          key_fill--;
          push_result(ST_OK, 1'b0, '0, '0, 1'b1);
        end
      end
      CMD_QUERY: begin
        push_result(ST_OK, pos >= 0, '0, '0, 1'b1);
      end
      default: begin
        if (key_fill == 0) begin
          push_result(ST_OK, 1'b0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < key_fill; i++)
            push_result(ST_OK, 1'b0, key_banks[i], key_sensors[i], i + 1 == key_fill);
        end
      end
    endcase
  endfunction

  // Predict on each accepted request, compare each shown result
  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      key_fill = 0;
      expected_results.delete();
    end else begin
      if (start && !busy)
        apply_request(cmd_t'(in_cmd), in_key_bank, in_key_sensor);
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result with no request pending: bank %0d sensor %0d", out_bank, out_sensor);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatch_count++;
          end
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_hit);
            mismatch_count++;
          end
          if (out_entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
            mismatch_count++;
          end
          if (out_bank !== want.bank) begin
            $error("out_bank: expected %0d, got %0d", want.bank, out_bank);
            mismatch_count++;
          end
          if (out_sensor !== want.sensor) begin
            $error("out_sensor: expected %0d, got %0d", want.sensor, out_sensor);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            mismatch_count++;
          end
        end
      end
    end
    results_outstanding = expected_results.size();
  end

endmodule

// File: tb/unique_key_set_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_key_set_table_test
// Drives add, remove, query and dump requests into the key set table: a
// directed pass over empty, full, duplicate and missing cases, then random
// fill and drain phases over a small key pool with random request gaps. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module unique_key_set_table_test;
  import ukst_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int RANDOM_COUNT = 300;
  localparam int POOL_SIZE    = 20;
  localparam int CYCLE_LIMIT  = 200000;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [1:0]                 in_cmd;
  logic [KEY_W-1:0]           in_key_bank;
  logic [KEY_W-1:0]           in_key_sensor;
  logic                       out_valid;
  logic [1:0]                 out_status;
  logic                       out_hit;
  logic [ENTRY_COUNT_W-1:0]   out_entry_count;
  logic [KEY_W-1:0]           out_bank;
  logic [KEY_W-1:0]           out_sensor;
  logic                       out_last;
  int                         mismatch_count;
  int                         results_outstanding;
  int                         cycle_count;

  logic [KEY_W-1:0]           pool_bank [POOL_SIZE];
  logic [KEY_W-1:0]           pool_sensor [POOL_SIZE];
  logic                       gapless;

  unique_key_set_table #(.CAPACITY(CAPACITY)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_key_bank     (in_key_bank),
    .in_key_sensor   (in_key_sensor),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_hit         (out_hit),
    .out_entry_count (out_entry_count),
    .out_bank        (out_bank),
    .out_sensor      (out_sensor),
    .out_last        (out_last)
  );

  unique_key_set_table_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_key_bank         (in_key_bank),
    .in_key_sensor       (in_key_sensor),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_hit             (out_hit),
    .out_entry_count     (out_entry_count),
    .out_bank            (out_bank),
    .out_sensor          (out_sensor),
    .out_last            (out_last),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("unique_key_set_table_test: FAIL");
      $finish;
    end
  end

  // Hold one request until accepted; called just after a falling edge
  task automatic issue_request(cmd_t cmd, logic [KEY_W-1:0] bank, logic [KEY_W-1:0] sensor,
                               int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_key_bank   <= bank;
    in_key_sensor <= sensor;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Mostly keys from the pool so adds collide and removes find their target
  task automatic pick_key(output logic [KEY_W-1:0] bank, output logic [KEY_W-1:0] sensor);
    int idx;
    if ($urandom_range(0, 9) == 0) begin
      bank   = 8'($urandom_range(0, 255));
      sensor = 8'($urandom_range(0, 255));
    end else begin
      idx    = $urandom_range(0, POOL_SIZE - 1);
      bank   = pool_bank[idx];
      sensor = pool_sensor[idx];
    end
  endtask

  // Growing phases favor adds, draining phases favor removes
  function automatic cmd_t pick_cmd(bit growing);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CMD_DUMP;
    if (r < 25) return CMD_QUERY;
    if (r < 85) return growing ? CMD_ADD : CMD_REMOVE;
    return growing ? CMD_REMOVE : CMD_ADD;
  endfunction

  function automatic int pick_gap();
    return gapless ? 0 : $urandom_range(0, 9);
  endfunction

  initial begin
    logic [KEY_W-1:0] bank;
    logic [KEY_W-1:0] sensor;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_cmd        = CMD_ADD;
    in_key_bank   = '0;
    in_key_sensor = '0;
    gapless       = 1'b0;

    // Half the pool shares banks with the other half
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_bank[i]   = (i < POOL_SIZE / 2) ? 8'($urandom_range(0, 255))
                                           : pool_bank[i - POOL_SIZE / 2];
      pool_sensor[i] = 8'($urandom_range(0, 255));
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty dump, duplicates, misses, fill to capacity, full adds
    issue_request(CMD_DUMP, 8'h00, 8'h00, 0);
    issue_request(CMD_ADD, 8'h00, 8'h00, 1);
    issue_request(CMD_ADD, 8'hFF, 8'hFF, 0);
    issue_request(CMD_ADD, 8'h00, 8'h00, 0);
    issue_request(CMD_QUERY, 8'hFF, 8'hFF, 2);
    issue_request(CMD_QUERY, 8'h00, 8'hFF, 0);
    issue_request(CMD_REMOVE, 8'hFF, 8'h00, 0);
    issue_request(CMD_REMOVE, 8'h00, 8'h00, 3);
    for (int i = 0; i < CAPACITY - 1; i++)
      issue_request(CMD_ADD, 8'(i * 17), 8'(8'hF0 ^ i), i % 2);
    issue_request(CMD_ADD, 8'h5A, 8'hA5, 0);
    issue_request(CMD_ADD, 8'hFF, 8'hFF, 0);
    issue_request(CMD_DUMP, 8'h00, 8'h00, 0);
    issue_request(CMD_REMOVE, 8'(7 * 17), 8'(8'hF0 ^ 7), 0);
    issue_request(CMD_DUMP, 8'hFF, 8'hFF, 1);

    // Random: alternate fill and drain phases, with gapless stretches
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      if ($urandom_range(0, 24) == 0) gapless = ~gapless;
      pick_key(bank, sensor);
      issue_request(pick_cmd(((n / 40) % 2) == 0), bank, sensor, pick_gap());
    end
    start <= 1'b0;

    // Drain the remaining results, then let the block settle
    while (results_outstanding != 0) @(negedge clk);
    repeat (CAPACITY + 4) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("unique_key_set_table_test: PASS");
    end else begin
      $display("unique_key_set_table_test: FAIL");
    end
    $finish;
  end

endmodule
